### src/tlv_message_validator_defines.svh
// Assertion macros used by the validator RTL (tlvmv_walker).
// Define ASSERT_OFF to drop every assertion; the modules need clk_i and rst_ni in scope.
`ifndef TLV_MESSAGE_VALIDATOR_DEFINES_SVH
`define TLV_MESSAGE_VALIDATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define TLVMV_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tlvmv assertion failed");
`define TLVMV_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("tlvmv assertion failed");
`else
`define TLVMV_ASSERT(name, prop)
`define TLVMV_ASSERT_ALWAYS(name, prop)
`endif
`endif

### src/tlvmv_pkg.sv
// Types, codes and constants of the TLV message validator.
// No dependencies; imported by every module of the block.
package tlvmv_pkg;

  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [PosW-1:0] HdrBytes = 17'd4;

  typedef enum logic [1:0] {
    CFG_ID_BYTES  = 2'd0,
    CFG_NONCE     = 2'd1,
    CFG_NEIGH_LEN = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    FF_NONE      = 2'd0,
    FF_TLV_SHORT = 2'd1,
    FF_OVERRUN   = 2'd2
  } frame_fault_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_INCOMPLETE = 4'd2,
    ST_TLV_SHORT  = 4'd3,
    ST_OVERRUN    = 4'd4,
    ST_PADN       = 4'd5,
    ST_HELLO      = 4'd6,
    ST_NEIGH      = 4'd7,
    ST_DATA       = 4'd8,
    ST_ACK        = 4'd9,
    ST_GOAWAY     = 4'd10
  } status_e;

  localparam logic [7:0] TypePad1   = 8'd0;
  localparam logic [7:0] TypePadN   = 8'd1;
  localparam logic [7:0] TypeHello  = 8'd2;
  localparam logic [7:0] TypeNeigh  = 8'd3;
  localparam logic [7:0] TypeData   = 8'd4;
  localparam logic [7:0] TypeAck    = 8'd5;
  localparam logic [7:0] TypeGoaway = 8'd6;

  localparam logic [6:0] IdBytesRst   = 7'd8;
  localparam logic [6:0] NonceRst     = 7'd4;
  localparam logic [7:0] NeighLenRst  = 8'd18;

  typedef struct packed {
    logic [6:0] id_bytes;
    logic [6:0] nonce_bytes;
    logic [7:0] neighbour_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] entry_count;
  } result_t;

endpackage

### src/tlv_message_validator.sv
// TLV message validator: takes a datagram one byte per cycle and gives one status word
// per datagram. Built from tlvmv_pkg, tlvmv_cfg_regs, tlvmv_in_stage and tlvmv_walker.
//
// The block takes one byte per clock cycle with no gaps needed between datagrams. Each byte
// sits in an input register while the walker updates the header, entry and fault state; on
// the byte marked tlast the status and entry count land in the result register, so a last
// byte accepted at the input passes the input register and then the result register before
// m_axis_tvalid rises. The input register keeps bytes flowing while a result waits on
// m_axis_tready; only a last byte meeting an untaken result stalls the input.
// Configuration writes take effect at once and are meant for an idle block.
module tlv_message_validator import tlvmv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [3:0] status, [19:4] entry_count, [23:20] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t    cfg;
  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t result;

  assign s_item.data_byte = s_axis_tdata;
  assign s_item.last_byte = s_axis_tlast;

  tlvmv_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tlvmv_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .take_i    (take),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  tlvmv_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (item_valid),
    .in_item_i    (item),
    .take_o       (take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

  assign m_axis_tdata = {4'b0000, result.entry_count, result.status};

endmodule

### src/tlvmv_cfg_regs.sv
// Configuration register file of the TLV message validator.
// Depends on tlvmv_pkg for register codes and the cfg_t bundle.
module tlvmv_cfg_regs import tlvmv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_ID_BYTES:  cfg_d.id_bytes         = cfg_data_i[6:0];
        CFG_NONCE:     cfg_d.nonce_bytes      = cfg_data_i[6:0];
        CFG_NEIGH_LEN: cfg_d.neighbour_length = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_bytes         <= IdBytesRst;
      cfg_q.nonce_bytes      <= NonceRst;
      cfg_q.neighbour_length <= NeighLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/tlvmv_in_stage.sv
// Input register of the TLV message validator: holds one received word.
// Depends on tlvmv_pkg for the item_t bundle.
module tlvmv_in_stage import tlvmv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  item_t s_item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_ready_o = !valid_q || take_i;
  assign valid_o   = valid_q;
  assign item_o    = item_q;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

endmodule

### src/tlvmv_walker.sv
// Datagram walker of the TLV message validator: header, entry walk, checks, result register.
// Depends on tlvmv_pkg and tlv_message_validator_defines.svh.
`include "tlv_message_validator_defines.svh"

module tlvmv_walker import tlvmv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  input  item_t   in_item_i,
  output logic    take_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     len_q, len_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      remain_q, remain_d;
  frame_fault_e    ff_q, ff_d;
  status_e         fault_q, fault_d;
  logic [15:0]     seen_q, seen_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic [7:0]      b;
  logic            take;
  logic [15:0]     len_n;
  phase_e          phase_n;
  logic [7:0]      type_n;
  logic [7:0]      remain_n;
  frame_fault_e    ff_n;
  status_e         fault_n;
  logic [15:0]     seen_n;
  logic [PosW-1:0] body_end;
  logic [PosW:0]   pos_inc;
  logic [PosW-1:0] count_n;
  logic            in_body;
  logic [7:0]      idn;
  logic [7:0]      id2;
  logic            len_bad;
  status_e         len_code;
  status_e         status_n;

  assign b    = in_item_i.data_byte;
  assign take = in_valid_i && (!in_item_i.last_byte || !out_valid_q || out_ready_i);
  assign idn  = {1'b0, cfg_i.id_bytes} + {1'b0, cfg_i.nonce_bytes};
  assign id2  = {cfg_i.id_bytes, 1'b0};

  always_comb begin
    len_bad  = 1'b0;
    len_code = ST_OK;
    case (type_q)
      TypeHello: begin
        len_bad  = (b != {1'b0, cfg_i.id_bytes}) && (b != id2);
        len_code = ST_HELLO;
      end
      TypeNeigh: begin
        len_bad  = b != cfg_i.neighbour_length;
        len_code = ST_NEIGH;
      end
      TypeData: begin
        len_bad  = b <= idn;
        len_code = ST_DATA;
      end
      TypeAck: begin
        len_bad  = b != idn;
        len_code = ST_ACK;
      end
      TypeGoaway: begin
        len_bad  = b == 8'd0;
        len_code = ST_GOAWAY;
      end
      default: begin
        len_bad  = 1'b0;
        len_code = ST_OK;
      end
    endcase
  end

  always_comb begin
    len_n = len_q;
    if (pos_q == 17'd2) begin
      len_n = {b, 8'h00};
    end else if (pos_q == 17'd3) begin
      len_n = {len_q[15:8], b};
    end
    body_end = {1'b0, len_n} + HdrBytes;
    in_body  = (pos_q >= HdrBytes) && (pos_q < body_end);

    phase_n  = phase_q;
    type_n   = type_q;
    remain_n = remain_q;
    fault_n  = fault_q;
    seen_n   = seen_q;
    if (in_body) begin
      case (phase_q)
        PH_TYPE: begin
          if (seen_q != 16'hFFFF) begin
            seen_n = seen_q + 16'd1;
          end
          type_n = b;
          if (b != TypePad1) begin
            phase_n = PH_LEN;
          end
        end
        PH_LEN: begin
          if (len_bad && fault_q == ST_OK) begin
            fault_n = len_code;
          end
          remain_n = b;
          phase_n  = (b != 8'd0) ? PH_VALUE : PH_TYPE;
        end
        default: begin
          if (type_q == TypePadN && b != 8'd0 && fault_q == ST_OK) begin
            fault_n = ST_PADN;
          end
          remain_n = remain_q - 8'd1;
          if (remain_n == 8'd0) begin
            phase_n = PH_TYPE;
          end
        end
      endcase
    end

    pos_inc = {1'b0, pos_q} + 18'd1;
    ff_n    = ff_q;
    if (pos_q >= 17'd3 && pos_inc == {1'b0, body_end}) begin
      case (phase_n)
        PH_LEN:   ff_n = FF_TLV_SHORT;
        PH_VALUE: ff_n = FF_OVERRUN;
        default:  ff_n = FF_NONE;
      endcase
    end

    count_n = (pos_q == PosMax) ? PosMax : pos_inc[PosW-1:0];

    if (count_n < HdrBytes) begin
      status_n = ST_SHORT;
    end else if (body_end > count_n) begin
      status_n = ST_INCOMPLETE;
    end else if (ff_n == FF_TLV_SHORT) begin
      status_n = ST_TLV_SHORT;
    end else if (ff_n == FF_OVERRUN) begin
      status_n = ST_OVERRUN;
    end else begin
      status_n = fault_n;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    phase_d  = phase_q;
    type_d   = type_q;
    remain_d = remain_q;
    ff_d     = ff_q;
    fault_d  = fault_q;
    seen_d   = seen_q;
    if (take) begin
      if (in_item_i.last_byte) begin
        pos_d    = '0;
        len_d    = '0;
        phase_d  = PH_TYPE;
        type_d   = '0;
        remain_d = '0;
        ff_d     = FF_NONE;
        fault_d  = ST_OK;
        seen_d   = '0;
      end else begin
        pos_d    = count_n;
        len_d    = len_n;
        phase_d  = phase_n;
        type_d   = type_n;
        remain_d = remain_n;
        ff_d     = ff_n;
        fault_d  = fault_n;
        seen_d   = seen_n;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (take && in_item_i.last_byte) begin
      out_valid_d       = 1'b1;
      out_d.status      = status_n;
      out_d.entry_count = (status_n == ST_OK) ? seen_n : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      phase_q     <= PH_TYPE;
      type_q      <= '0;
      remain_q    <= '0;
      ff_q        <= FF_NONE;
      fault_q     <= ST_OK;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      len_q       <= len_d;
      phase_q     <= phase_d;
      type_q      <= type_d;
      remain_q    <= remain_d;
      ff_q        <= ff_d;
      fault_q     <= fault_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign take_o       = take;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  `TLVMV_ASSERT(a_clear_after_last, take && in_item_i.last_byte |=> pos_q == '0)
  `TLVMV_ASSERT(a_count_only_ok, out_valid_q && out_q.status != ST_OK |-> out_q.entry_count == '0)
  `TLVMV_ASSERT(a_fault_in_body, ff_q != FF_NONE |-> pos_q >= HdrBytes)
  `TLVMV_ASSERT_ALWAYS(a_status_range, out_valid_q |-> out_q.status <= ST_GOAWAY)

endmodule

### tb/sv/tlv_message_validator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tlv_message_validator: directed datagrams with pinned or modelled
// results, then random datagrams under several register settings checked against an in-bench model of the TLV walk.
// Depends on tlvmv_pkg and the validator RTL.
module tlv_message_validator_tb;
  import tlvmv_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumRows = 24;
  localparam int unsigned NumPhases = 6;

  typedef logic [0:23][7:0] frame_t;

  typedef struct packed {
    logic [4:0] n;
    frame_t     f;
    logic       pinned;
    status_e    st;
    logic [15:0] cnt;
  } row_t;

  typedef struct packed {
    logic    pinned;
    result_t res;
  } known_t;

  localparam row_t Plan [NumRows] = '{
    '{5'd1,  192'hFF000000_00000000_00000000_00000000_00000000_00000000, 1'b1, ST_SHORT, 16'd0},
    '{5'd3,  192'h00FF0000_00000000_00000000_00000000_00000000_00000000, 1'b1, ST_SHORT, 16'd0},
    '{5'd4,  192'hFFFF0000_00000000_00000000_00000000_00000000_00000000, 1'b1, ST_OK, 16'd0},
    '{5'd6,  192'hFFFFFFFF_00000000_00000000_00000000_00000000_00000000, 1'b1, ST_INCOMPLETE,
      16'd0},
    '{5'd7,  192'h00000003_00000000_00000000_00000000_00000000_00000000, 1'b1, ST_OK, 16'd3},
    '{5'd5,  192'h00000001_07000000_00000000_00000000_00000000_00000000, 1'b1, ST_TLV_SHORT,
      16'd0},
    '{5'd6,  192'h00000002_07050000_00000000_00000000_00000000_00000000, 1'b1, ST_OVERRUN,
      16'd0},
    '{5'd8,  192'h00000004_01020000_00000000_00000000_00000000_00000000, 1'b1, ST_OK, 16'd1},
    '{5'd8,  192'h00000004_01020001_00000000_00000000_00000000_00000000, 1'b1, ST_PADN, 16'd0},
    '{5'd14, 192'h0000000A_0208AAAA_AAAAAAAA_AAAA0000_00000000_00000000, 1'b0, ST_OK, 16'd0},
    '{5'd22, 192'h00000012_0210AAAA_AAAAAAAA_AAAAAAAA_AAAAAAAA_AAAA0000, 1'b0, ST_OK, 16'd0},
    '{5'd9,  192'h00000005_0203AAAA_AA000000_00000000_00000000_00000000, 1'b1, ST_HELLO, 16'd0},
    '{5'd24, 192'h00000014_0312AAAA_AAAAAAAA_AAAAAAAA_AAAAAAAA_AAAAAAAA, 1'b0, ST_OK, 16'd0},
    '{5'd6,  192'h00000002_03000000_00000000_00000000_00000000_00000000, 1'b1, ST_NEIGH, 16'd0},
    '{5'd19, 192'h0000000F_040DAAAA_AAAAAAAA_AAAAAAAA_AAAAAA00_00000000, 1'b0, ST_OK, 16'd0},
    '{5'd18, 192'h0000000E_040CAAAA_AAAAAAAA_AAAAAAAA_AAAA0000_00000000, 1'b1, ST_DATA, 16'd0},
    '{5'd18, 192'h0000000E_050CAAAA_AAAAAAAA_AAAAAAAA_AAAA0000_00000000, 1'b0, ST_OK, 16'd0},
    '{5'd7,  192'h00000003_0501AA00_00000000_00000000_00000000_00000000, 1'b1, ST_ACK, 16'd0},
    '{5'd6,  192'h00000002_06000000_00000000_00000000_00000000_00000000, 1'b1, ST_GOAWAY,
      16'd0},
    '{5'd13, 192'h00000009_0601AAFF_008002BB_CC000000_00000000_00000000, 1'b0, ST_OK, 16'd0},
    '{5'd9,  192'h00000001_00FFFFFF_FF000000_00000000_00000000_00000000, 1'b1, ST_OK, 16'd1},
    '{5'd10, 192'h00000006_01010102_01AA0000_00000000_00000000_00000000, 1'b1, ST_PADN, 16'd0},
    '{5'd7,  192'h00000003_0203AA00_00000000_00000000_00000000_00000000, 1'b1, ST_OVERRUN,
      16'd0},
    '{5'd6,  192'h00000005_02030000_00000000_00000000_00000000_00000000, 1'b1, ST_INCOMPLETE,
      16'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_ID_BYTES;
  logic [7:0]  cfg_data_i = 8'h00;

  logic        calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  logic [7:0]  frame_q[$];
  logic [7:0]  body_q[$];
  known_t      known_result_q[$];
  result_t     pending_status_q[$];

  // register copy used by the model
  int unsigned cur_id = 32'(IdBytesRst);
  int unsigned cur_nonce = 32'(NonceRst);
  int unsigned cur_neigh = 32'(NeighLenRst);

  // register values the datagram generator aims at
  int unsigned ph_id = 32'(IdBytesRst);
  int unsigned ph_nonce = 32'(NonceRst);
  int unsigned ph_neigh = 32'(NeighLenRst);

  // datagram walk state
  int unsigned  tlv_pos = 0;
  logic [15:0]  tlv_body_len = '0;
  phase_e       tlv_phase = PH_TYPE;
  logic [7:0]   tlv_type = '0;
  logic [7:0]   tlv_left = '0;
  frame_fault_e tlv_frame_fault = FF_NONE;
  status_e      tlv_first_fault = ST_OK;
  logic [15:0]  tlv_entries = '0;

  tlv_message_validator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tlast (s_axis_tlast),   // last_byte
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [3:0] status, [19:4] entry_count, [23:20] zero
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_datagram();
    tlv_pos = 0;
    tlv_body_len = '0;
    tlv_phase = PH_TYPE;
    tlv_type = '0;
    tlv_left = '0;
    tlv_frame_fault = FF_NONE;
    tlv_first_fault = ST_OK;
    tlv_entries = '0;
  endfunction

  function automatic void hold_first_fault(input status_e code);
    if (tlv_first_fault == ST_OK) tlv_first_fault = code;
  endfunction

  function automatic void check_entry_length(input logic [7:0] b);
    int unsigned idn;
    int unsigned len;
    idn = cur_id + cur_nonce;
    len = 32'(b);
    case (tlv_type)
      TypeHello:  if (len != cur_id && len != 2 * cur_id) hold_first_fault(ST_HELLO);
      TypeNeigh:  if (len != cur_neigh) hold_first_fault(ST_NEIGH);
      TypeData:   if (len < idn + 1) hold_first_fault(ST_DATA);
      TypeAck:    if (len != idn) hold_first_fault(ST_ACK);
      TypeGoaway: if (len == 0) hold_first_fault(ST_GOAWAY);
      default: ;
    endcase
  endfunction

  function automatic void walk_body_byte(input logic [7:0] b);
    case (tlv_phase)
      PH_TYPE: begin
        if (tlv_entries != 16'hFFFF) tlv_entries = tlv_entries + 16'd1;
        tlv_type = b;
        if (b != TypePad1) tlv_phase = PH_LEN;
      end
      PH_LEN: begin
        check_entry_length(b);
        tlv_left = b;
        tlv_phase = (b != 8'd0) ? PH_VALUE : PH_TYPE;
      end
      default: begin
        if (tlv_type == TypePadN && b != 8'd0) hold_first_fault(ST_PADN);
        tlv_left = tlv_left - 8'd1;
        if (tlv_left == 8'd0) tlv_phase = PH_TYPE;
      end
    endcase
  endfunction

  function automatic void validate_byte(input logic [7:0] b, input logic last,
                                        output logic emit, output result_t res);
    int unsigned pos;
    int unsigned cnt;
    status_e st;
    pos = tlv_pos;
    emit = 1'b0;
    res = '0;
    if (pos == 2) tlv_body_len = {b, 8'h00};
    else if (pos == 3) tlv_body_len[7:0] = b;
    else if (pos >= 4 && pos < 4 + 32'(tlv_body_len)) walk_body_byte(b);
    if (pos >= 3 && pos + 1 == 4 + 32'(tlv_body_len)) begin
      case (tlv_phase)
        PH_LEN:   tlv_frame_fault = FF_TLV_SHORT;
        PH_VALUE: tlv_frame_fault = FF_OVERRUN;
        default:  tlv_frame_fault = FF_NONE;
      endcase
    end
    cnt = (pos < 32'(PosMax)) ? pos + 1 : 32'(PosMax);
    tlv_pos = cnt;
    if (last) begin
      if (cnt < 4) st = ST_SHORT;
      else if (32'(tlv_body_len) + 4 > cnt) st = ST_INCOMPLETE;
      else if (tlv_frame_fault == FF_TLV_SHORT) st = ST_TLV_SHORT;
      else if (tlv_frame_fault == FF_OVERRUN) st = ST_OVERRUN;
      else st = tlv_first_fault;
      res.status = st;
      res.entry_count = (st == ST_OK) ? tlv_entries : 16'd0;
      emit = 1'b1;
      clear_datagram();
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    logic    emit;
    result_t got;
    result_t want;
    known_t  k;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_ID_BYTES:  cur_id = 32'(cfg_data_i[6:0]);
          CFG_NONCE:     cur_nonce = 32'(cfg_data_i[6:0]);
          CFG_NEIGH_LEN: cur_neigh = 32'(cfg_data_i);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        validate_byte(s_axis_tdata, s_axis_tlast, emit, got);
        if (emit) begin
          k = known_result_q.pop_front();
          pending_status_q.push_back(k.pinned ? k.res : got);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_status_q.size() == 0) begin
          $display("%0t: result word with none expected, status %0d count %0d", $time,
                   m_axis_tdata[3:0], m_axis_tdata[19:4]);
          mismatches++;
        end else begin
          want = pending_status_q.pop_front();
          if (m_axis_tdata[3:0] != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_axis_tdata[3:0]);
            mismatches++;
          end
          if (m_axis_tdata[19:4] != want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                     m_axis_tdata[19:4]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tlv_message_validator: mismatch");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic pinned, input status_e st, input logic [15:0] cnt);
    known_t k;
    k.pinned = pinned;
    k.res.status = st;
    k.res.entry_count = cnt;
    known_result_q.push_back(k);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_entry();
    int unsigned pick;
    int unsigned idn;
    int unsigned len;
    logic [7:0] kind;
    pick = $urandom_range(99);
    idn = ph_id + ph_nonce;
    if (pick < 15) begin
      body_q.push_back(TypePad1);
      return;
    end
    if (pick < 30) kind = TypePadN;
    else if (pick < 42) kind = TypeHello;
    else if (pick < 52) kind = TypeNeigh;
    else if (pick < 62) kind = TypeData;
    else if (pick < 72) kind = TypeAck;
    else if (pick < 82) kind = TypeGoaway;
    else kind = 8'($urandom_range(7, 255));
    case (kind)
      TypePadN:   len = $urandom_range(0, 6);
      TypeHello:  len = $urandom_range(1) ? ph_id : 2 * ph_id;
      TypeNeigh:  len = ph_neigh;
      TypeData:   len = idn + 1 + $urandom_range(0, 3);
      TypeAck:    len = idn;
      TypeGoaway: len = $urandom_range(1, 4);
      default:    len = $urandom_range(0, 6);
    endcase
    if ($urandom_range(99) < 15 || len > 255) len = $urandom_range(0, 12);
    body_q.push_back(kind);
    body_q.push_back(len[7:0]);
    repeat (len) begin
      if (kind == TypePadN && $urandom_range(99) >= 10) body_q.push_back(8'h00);
      else body_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic build_datagram();
    int unsigned shape;
    int unsigned mutate;
    int unsigned drop;
    logic [15:0] declared;
    frame_q.delete();
    body_q.delete();
    shape = $urandom_range(99);
    if (shape < 5) begin
      repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(255)));
    end else if (shape < 12) begin
      repeat ($urandom_range(4, 30)) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 5)) add_entry();
      declared = 16'(body_q.size());
      mutate = $urandom_range(99);
      if (mutate < 8) begin
        declared = 16'($urandom_range(0, body_q.size()));
      end else if (mutate < 15 && body_q.size() != 0) begin
        body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(255));
      end
      frame_q.push_back(8'($urandom_range(255)));
      frame_q.push_back(8'($urandom_range(255)));
      frame_q.push_back(declared[15:8]);
      frame_q.push_back(declared[7:0]);
      foreach (body_q[i]) frame_q.push_back(body_q[i]);
      mutate = $urandom_range(99);
      if (mutate < 10) begin
        repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(255)));
      end else if (mutate < 18) begin
        drop = $urandom_range(1, 4);
        repeat (drop) if (frame_q.size() > 1) void'(frame_q.pop_back());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ph_bytes;
    int unsigned ph_count;
    logic [7:0] id_raw;
    logic [7:0] nonce_raw;
    logic [7:0] neigh_raw;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      frame_q.delete();
      for (int k = 0; k < int'(Plan[r].n); k++) frame_q.push_back(Plan[r].f[k]);
      send_frame(Plan[r].pinned, Plan[r].st, Plan[r].cnt);
    end
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1: begin id_raw = 8'hFF; nonce_raw = 8'h7F; neigh_raw = 8'hFF; end
          2: begin id_raw = 8'h01; nonce_raw = 8'h01; neigh_raw = 8'h00; end
          3: begin id_raw = 8'h80; nonce_raw = 8'h00; neigh_raw = 8'h01; end
          4: begin
            id_raw = 8'($urandom_range(255));
            nonce_raw = 8'($urandom_range(255));
            neigh_raw = 8'($urandom_range(255));
          end
          default: begin id_raw = 8'd8; nonce_raw = 8'd4; neigh_raw = 8'd18; end
        endcase
        write_reg(CFG_ID_BYTES, id_raw);
        write_reg(CFG_NONCE, nonce_raw);
        write_reg(CFG_NEIGH_LEN, neigh_raw);
        write_reg(CFG_UNUSED, 8'($urandom_range(255)));
        cfg_valid_i <= 1'b0;
        ph_id = 32'(id_raw[6:0]);
        ph_nonce = 32'(nonce_raw[6:0]);
        ph_neigh = 32'(neigh_raw);
      end
      // hold both sides busy for one whole phase
      calm <= (p == 2);
      ph_bytes = 0;
      ph_count = 0;
      while (ph_bytes < 290 || ph_count < 8) begin
        build_datagram();
        send_frame(1'b0, ST_OK, 16'd0);
        ph_bytes += frame_q.size();
        ph_count++;
      end
      s_axis_tvalid <= 1'b0;
    end
    calm <= 1'b0;

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tlv_message_validator: match");
    end else begin
      $display("tlv_message_validator: mismatch");
    end
    $finish;
  end

endmodule
